// ===== rtl/core/hsoa_pkg.sv =====
// types and constants shared by the keyed record store
// holds the word formats, memory entry layout, mode and status codes
// no dependencies
`default_nettype none

package hsoa_pkg;

  localparam int KEY_W    = 31;
  localparam int PRICE_W  = 31;
  localparam int QTY_W    = 32;
  localparam int SLOT_W   = 7;

  localparam logic signed [QTY_W-1:0] QTY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QTY_W-1:0] QTY_MIN = 32'sh8000_0000;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_NEW_HOME     = 4'd0,
    ST_MERGED_HOME  = 4'd1,
    ST_NEW_SPILL    = 4'd2,
    ST_MERGED_SPILL = 4'd3,
    ST_FOUND        = 4'd4,
    ST_ABSENT       = 4'd5,
    ST_DELETED      = 4'd6,
    ST_FULL         = 4'd7,
    ST_CLEARED      = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_MOD,
    S_HOME_RD,
    S_HOME_CHK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    mode_t                    mode;
    logic [KEY_W-1:0]         key;
    logic [PRICE_W-1:0]       price;
    logic signed [QTY_W-1:0]  quantity;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    slot_t                    slot_index;
    logic [PRICE_W-1:0]       found_price;
    logic signed [QTY_W-1:0]  found_quantity;
  } out_word_t;

  // one record as kept in the home and overflow memories
  typedef struct packed {
    logic                     valid;
    logic [KEY_W-1:0]         key;
    logic [PRICE_W-1:0]       price;
    logic signed [QTY_W-1:0]  quantity;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsoa_ram.sv =====
// generic single write port, single read port ram with registered read
// used for the home slots and the overflow area
// no dependencies
`default_nettype none

module hsoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/hash_store_with_overflow_area_top.sv =====
// keyed record store: home slots at key mod HOME_SLOTS plus an append-only overflow area
// depends on hsoa_pkg and hsoa_ram
//
//   channel  ports                          word
//   input    in_valid, in_ready, in_data    mode, key, price, quantity
//   output   out_valid, out_ready, out_data status, slot_index, found_price, found_quantity
//
// one item at a time: after accept come the key mod, the home read and the home check;
// when the home slot does not decide, a scan of the filled overflow entries follows, then done;
// key mod is two-step (reciprocal product, then remainder); one overflow read per cycle
// reset and clear run a pass over every home memory slot, with in_ready low
// a finished word waits in the output register; the next item is taken meanwhile
`default_nettype none

module hash_store_with_overflow_area_top #(
  parameter int HOME_SLOTS  = 64,
  parameter int SPILL_SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hsoa_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hsoa_pkg::out_word_t     out_data
);

  localparam int HAW     = $clog2(HOME_SLOTS);
  localparam int SAW     = (SPILL_SLOTS > 1) ? $clog2(SPILL_SLOTS) : 1;
  localparam int FW      = $clog2(SPILL_SLOTS + 1);
  localparam int ENTRY_W = $bits(hsoa_pkg::entry_t);
  localparam int PROD_W  = 2 * hsoa_pkg::KEY_W + 1;
  localparam int MOD_SH  = hsoa_pkg::KEY_W + HAW;

  // reciprocal of HOME_SLOTS, exact for every key below 2^KEY_W
  localparam logic [hsoa_pkg::KEY_W:0] MOD_M = (hsoa_pkg::KEY_W + 1)'(
    ((64'd1 << MOD_SH) + 64'(HOME_SLOTS) - 64'd1) / 64'(HOME_SLOTS));
  localparam logic [hsoa_pkg::KEY_W-1:0] HOME_D = (hsoa_pkg::KEY_W)'(HOME_SLOTS);

  localparam logic [HAW-1:0] HOME_LAST = HAW'(HOME_SLOTS - 1);
  localparam logic [FW-1:0]  SPILL_N   = FW'(SPILL_SLOTS);
  localparam hsoa_pkg::slot_t HOME_BASE = hsoa_pkg::slot_t'(HOME_SLOTS);

  function automatic logic signed [hsoa_pkg::QTY_W-1:0] sat_add(
    input logic signed [hsoa_pkg::QTY_W-1:0] a,
    input logic signed [hsoa_pkg::QTY_W-1:0] b
  );
    logic signed [hsoa_pkg::QTY_W:0] s;
    begin
      s = {a[hsoa_pkg::QTY_W-1], a} + {b[hsoa_pkg::QTY_W-1], b};
      if (s[hsoa_pkg::QTY_W] != s[hsoa_pkg::QTY_W-1]) begin
        sat_add = s[hsoa_pkg::QTY_W] ? hsoa_pkg::QTY_MIN : hsoa_pkg::QTY_MAX;
      end else begin
        sat_add = s[hsoa_pkg::QTY_W-1:0];
      end
    end
  endfunction

  function automatic hsoa_pkg::out_word_t mk_res(
    input hsoa_pkg::status_t                  st,
    input hsoa_pkg::slot_t                    slot,
    input logic [hsoa_pkg::PRICE_W-1:0]       price,
    input logic signed [hsoa_pkg::QTY_W-1:0]  qty
  );
    hsoa_pkg::out_word_t r;
    begin
      r.status         = st;
      r.slot_index     = slot;
      r.found_price    = price;
      r.found_quantity = qty;
      mk_res = r;
    end
  endfunction

  // control
  hsoa_pkg::state_t    state_r, state_nxt;
  logic [HAW-1:0]      sweep_r, sweep_nxt;
  logic                boot_r, boot_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [FW-1:0]       scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  // payload
  hsoa_pkg::in_word_t  req_r, req_nxt;
  logic [HAW-1:0]      h_r, h_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SAW-1:0]      pidx_r, pidx_nxt;
  hsoa_pkg::out_word_t res_r, res_nxt;
  hsoa_pkg::out_word_t out_r, out_nxt;

  // memories
  logic                home_we;
  logic [HAW-1:0]      home_waddr, home_raddr;
  hsoa_pkg::entry_t    home_wdata, home_rdata;
  logic                spill_we;
  logic [SAW-1:0]      spill_waddr, spill_raddr;
  hsoa_pkg::entry_t    spill_wdata, spill_rdata;

  logic [PROD_W-1:0]   key_prod;
  logic [hsoa_pkg::KEY_W-1:0] quot_d;
  logic [hsoa_pkg::KEY_W-1:0] key_rem;
  logic                home_hit;
  logic                spill_hit;
  logic signed [hsoa_pkg::QTY_W-1:0] merge_base;
  logic signed [hsoa_pkg::QTY_W-1:0] merged_qty;
  hsoa_pkg::entry_t    new_entry;
  hsoa_pkg::slot_t     pidx_slot;
  hsoa_pkg::slot_t     fill_slot;

  hsoa_ram #(.WIDTH(ENTRY_W), .DEPTH(HOME_SLOTS)) u_home_ram (
    .clk   (clk),
    .we    (home_we),
    .waddr (home_waddr),
    .wdata (home_wdata),
    .raddr (home_raddr),
    .rdata (home_rdata)
  );

  hsoa_ram #(.WIDTH(ENTRY_W), .DEPTH(SPILL_SLOTS)) u_spill_ram (
    .clk   (clk),
    .we    (spill_we),
    .waddr (spill_waddr),
    .wdata (spill_wdata),
    .raddr (spill_raddr),
    .rdata (spill_rdata)
  );

  // key mod HOME_SLOTS: reciprocal product taken at accept, remainder in the mod step
  assign key_prod = PROD_W'(in_data.key) * PROD_W'(MOD_M);
  assign quot_d   = (hsoa_pkg::KEY_W)'(prod_r[PROD_W-1:MOD_SH]) * HOME_D;
  assign key_rem  = req_r.key - quot_d;

  assign home_hit  = home_rdata.valid && (home_rdata.key == req_r.key);
  assign spill_hit = pend_r && spill_rdata.valid && (spill_rdata.key == req_r.key);

  // one saturating adder shared by home and overflow merges
  assign merge_base = (state_r == hsoa_pkg::S_HOME_CHK) ? home_rdata.quantity
                                                       : spill_rdata.quantity;
  assign merged_qty = sat_add(req_r.quantity, merge_base);

  assign new_entry.valid    = 1'b1;
  assign new_entry.key      = req_r.key;
  assign new_entry.price    = req_r.price;
  assign new_entry.quantity = req_r.quantity;

  assign pidx_slot = hsoa_pkg::slot_t'(HOME_BASE + hsoa_pkg::slot_t'(pidx_r));
  assign fill_slot = hsoa_pkg::slot_t'(HOME_BASE + hsoa_pkg::slot_t'(fill_r[SAW-1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsoa_pkg::S_SWEEP;
      sweep_r     <= '0;
      boot_r      <= 1'b1;
      fill_r      <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      boot_r      <= boot_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    h_r    <= h_nxt;
    prod_r <= prod_nxt;
    pidx_r <= pidx_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    boot_nxt      = boot_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    req_nxt       = req_r;
    h_nxt         = h_r;
    prod_nxt      = prod_r;
    pidx_nxt      = pidx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;

    home_we     = 1'b0;
    home_waddr  = h_r;
    home_wdata  = new_entry;
    home_raddr  = h_r;
    spill_we    = 1'b0;
    spill_waddr = pidx_r;
    spill_wdata = new_entry;
    spill_raddr = scan_r[SAW-1:0];

    case (state_r)
      hsoa_pkg::S_SWEEP: begin
        home_we          = 1'b1;
        home_waddr       = sweep_r;
        home_wdata       = '0;
        fill_nxt         = '0;
        if (sweep_r == HOME_LAST) begin
          sweep_nxt = '0;
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = hsoa_pkg::S_IDLE;
          end else begin
            res_nxt   = mk_res(hsoa_pkg::ST_CLEARED, '0, '0, '0);
            state_nxt = hsoa_pkg::S_DONE;
          end
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      hsoa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt  = in_data;
          prod_nxt = key_prod;
          scan_nxt = '0;
          pend_nxt = 1'b0;
          if (in_data.mode == hsoa_pkg::MODE_CLEAR) begin
            fill_nxt  = '0;
            state_nxt = hsoa_pkg::S_SWEEP;
          end else begin
            state_nxt = hsoa_pkg::S_MOD;
          end
        end
      end

      hsoa_pkg::S_MOD: begin
        h_nxt     = key_rem[HAW-1:0];
        state_nxt = hsoa_pkg::S_HOME_RD;
      end

      hsoa_pkg::S_HOME_RD: begin
        state_nxt = hsoa_pkg::S_HOME_CHK;
      end

      hsoa_pkg::S_HOME_CHK: begin
        state_nxt = hsoa_pkg::S_SCAN;
        case (req_r.mode)
          hsoa_pkg::MODE_INSERT: begin
            if (!home_rdata.valid) begin
              home_we   = 1'b1;
              res_nxt   = mk_res(hsoa_pkg::ST_NEW_HOME, hsoa_pkg::slot_t'(h_r),
                                 req_r.price, req_r.quantity);
              state_nxt = hsoa_pkg::S_DONE;
            end else if (home_hit) begin
              home_we             = 1'b1;
              home_wdata.quantity = merged_qty;
              res_nxt   = mk_res(hsoa_pkg::ST_MERGED_HOME, hsoa_pkg::slot_t'(h_r),
                                 req_r.price, merged_qty);
              state_nxt = hsoa_pkg::S_DONE;
            end
          end
          hsoa_pkg::MODE_LOOKUP: begin
            if (home_hit) begin
              res_nxt   = mk_res(hsoa_pkg::ST_FOUND, hsoa_pkg::slot_t'(h_r),
                                 home_rdata.price, home_rdata.quantity);
              state_nxt = hsoa_pkg::S_DONE;
            end
          end
          hsoa_pkg::MODE_DELETE: begin
            if (home_hit) begin
              home_we          = 1'b1;
              home_wdata       = home_rdata;
              home_wdata.valid = 1'b0;
              res_nxt   = mk_res(hsoa_pkg::ST_DELETED, hsoa_pkg::slot_t'(h_r), '0, '0);
              state_nxt = hsoa_pkg::S_DONE;
            end
          end
          default: begin
            state_nxt = hsoa_pkg::S_IDLE;
          end
        endcase
      end

      hsoa_pkg::S_SCAN: begin
        // reads go out back to back; each compare sees the data of the previous read
        if (spill_hit) begin
          state_nxt   = hsoa_pkg::S_DONE;
          spill_waddr = pidx_r;
          case (req_r.mode)
            hsoa_pkg::MODE_INSERT: begin
              spill_we             = 1'b1;
              spill_wdata.quantity = merged_qty;
              res_nxt = mk_res(hsoa_pkg::ST_MERGED_SPILL, pidx_slot,
                               req_r.price, merged_qty);
            end
            hsoa_pkg::MODE_LOOKUP: begin
              res_nxt = mk_res(hsoa_pkg::ST_FOUND, pidx_slot,
                               spill_rdata.price, spill_rdata.quantity);
            end
            hsoa_pkg::MODE_DELETE: begin
              spill_we          = 1'b1;
              spill_wdata       = spill_rdata;
              spill_wdata.valid = 1'b0;
              res_nxt = mk_res(hsoa_pkg::ST_DELETED, pidx_slot, '0, '0);
            end
            default: begin
              state_nxt = hsoa_pkg::S_IDLE;
            end
          endcase
        end else if (scan_r < fill_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[SAW-1:0];
          scan_nxt = scan_r + 1'b1;
        end else begin
          // nothing left in flight and no match
          state_nxt = hsoa_pkg::S_DONE;
          pend_nxt  = 1'b0;
          if (req_r.mode == hsoa_pkg::MODE_INSERT) begin
            if (fill_r < SPILL_N) begin
              spill_we    = 1'b1;
              spill_waddr = fill_r[SAW-1:0];
              fill_nxt    = fill_r + 1'b1;
              res_nxt = mk_res(hsoa_pkg::ST_NEW_SPILL, fill_slot,
                               req_r.price, req_r.quantity);
            end else begin
              res_nxt = mk_res(hsoa_pkg::ST_FULL, '0, '0, '0);
            end
          end else begin
            res_nxt = mk_res(hsoa_pkg::ST_ABSENT, '0, '0, '0);
          end
        end
      end

      hsoa_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = hsoa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = hsoa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SPILL_N)
    else $error("overflow fill count beyond overflow area size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in work");

  a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == hsoa_pkg::S_DONE))
    else $error("result word appeared outside the done step");

  a_clear_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode == hsoa_pkg::MODE_CLEAR) |=> (fill_r == '0))
    else $error("clear did not empty the overflow area");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hsoa_pkg::S_IDLE) |-> (!home_we && !spill_we))
    else $error("memory written while idle");
`endif

endmodule

`default_nettype wire
